@@ hdl/rgp_pkg.sv @@
// ----------------------------------------------------------------------------
// rgp_pkg
// Shared types, constants and helpers of the retrigger glitch player.
// ----------------------------------------------------------------------------
package rgp_pkg;

    // store geometry and number formats
    localparam int MAX_FRAMES    = 65536;
    localparam int FRAME_AW      = $clog2(MAX_FRAMES);
    localparam int SAMPLE_BITS   = 16;
    localparam int FRAME_W       = 2 * SAMPLE_BITS;
    localparam int FRACTION_BITS = 8;
    localparam int LEN_W         = 17;
    localparam int SPEED_W       = 16;
    localparam int POS_W         = 16;
    localparam int PHASE_W       = POS_W + FRACTION_BITS;
    localparam int SPAN_W        = LEN_W + FRACTION_BITS;
    localparam int CH_W          = 2;

    // largest usable clip and grain lengths
    localparam logic [LEN_W-1:0] CLIP_MAX  = LEN_W'(MAX_FRAMES);
    localparam logic [LEN_W-1:0] GRAIN_MAX = LEN_W'(65536);

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_CLIP_LENGTH   = 2'd0;
    localparam logic [1:0] CFG_GRAIN_LENGTH  = 2'd1;
    localparam logic [1:0] CFG_PLAY_SPEED    = 2'd2;
    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd3;

    // channel count that selects mono playback
    localparam logic [CH_W-1:0] CH_MONO = CH_W'(1);

    typedef struct packed {
        logic                    operation;
        logic [15:0]             load_index;
        logic signed [15:0]      load_left;
        logic signed [15:0]      load_right;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0]      out_left;
        logic signed [15:0]      out_right;
        logic [15:0]             read_index;
    } out_item_t;

    typedef struct packed {
        logic [LEN_W-1:0]        clip_length;
        logic [LEN_W-1:0]        grain_length;
        logic [SPEED_W-1:0]      play_speed;
        logic [CH_W-1:0]         channel_count;
    } cfg_t;

    // item as it travels through the remainder pipeline
    typedef struct packed {
        logic                    tick;
        logic                    no_clip;
        logic [FRAME_AW-1:0]     load_index;
        logic [FRAME_W-1:0]      frame;
        logic [LEN_W-1:0]        dividend;
        logic [LEN_W-1:0]        rem;
    } pipe_item_t;

    // clip length saturated at the store depth
    function automatic logic [LEN_W-1:0] clip_limit(input logic [LEN_W-1:0] len);
        clip_limit = (len > CLIP_MAX) ? CLIP_MAX : len;
    endfunction

endpackage

@@ hdl/rgp_ram.sv @@
// ----------------------------------------------------------------------------
// rgp_ram
// Generic simple dual port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rgp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds its data while idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/rgp_phase.sv @@
// ----------------------------------------------------------------------------
// rgp_phase
// Playback position state: frame counter, grain position, trigger point and
// fixed point grain phase. Builds the raw read offset for each tick item.
// ----------------------------------------------------------------------------
module rgp_phase
    import rgp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  in_item_t         item,
    input  cfg_t             cfg,
    input  logic [LEN_W-1:0] clip,
    output pipe_item_t       entry
);

    logic [POS_W-1:0]   global_pos_reg,  global_pos_next;
    logic [POS_W-1:0]   segment_pos_reg, segment_pos_next;
    logic [POS_W-1:0]   trigger_pos_reg, trigger_pos_next;
    logic [PHASE_W-1:0] phase_reg,       phase_next;

    logic [LEN_W-1:0]   grain;
    logic [POS_W-1:0]   seg;
    logic               fire;
    logic [POS_W-1:0]   trig;
    logic [PHASE_W-1:0] phase;
    logic [LEN_W-1:0]   global_inc;
    logic [LEN_W-1:0]   segment_inc;
    logic [LEN_W-1:0]   segment_wrap;
    logic               clip_wrap;
    logic [SPAN_W-1:0]  span;
    logic [SPAN_W-1:0]  span_m1;
    logic [SPAN_W-1:0]  speed;
    logic [SPAN_W-1:0]  phase_sum;
    logic               is_tick;
    logic               no_clip;

    assign is_tick = (item.operation == OP_TICK);
    assign no_clip = (clip == '0);

    // effective grain length, zero acts as one, capped at GRAIN_MAX
    always_comb
    begin
        if (cfg.grain_length == '0)
        begin
            grain = LEN_W'(1);
        end
        else if (cfg.grain_length > GRAIN_MAX)
        begin
            grain = GRAIN_MAX;
        end
        else
        begin
            grain = cfg.grain_length;
        end
    end

    // grain start: latch trigger point and clear phase
    assign seg   = ({1'b0, segment_pos_reg} >= grain) ? '0 : segment_pos_reg;
    assign fire  = (seg == '0);
    assign trig  = fire ? global_pos_reg : trigger_pos_reg;
    assign phase = fire ? '0 : phase_reg;

    // position counters for the next tick
    assign global_inc   = {1'b0, global_pos_reg} + LEN_W'(1);
    assign segment_inc  = {1'b0, seg} + LEN_W'(1);
    assign clip_wrap    = (global_inc >= clip);
    assign segment_wrap = clip_wrap ? '0 : segment_inc;

    assign global_pos_next  = clip_wrap ? '0 : global_inc[POS_W-1:0];
    assign segment_pos_next = (segment_wrap >= grain) ? '0 : segment_wrap[POS_W-1:0];
    assign trigger_pos_next = trig;

    // phase step clamped below the span, one subtract wraps it
    assign span      = {grain, FRACTION_BITS'(0)};
    assign span_m1   = span - SPAN_W'(1);
    assign speed     = (SPAN_W'(cfg.play_speed) > span_m1) ? span_m1
                                                            : SPAN_W'(cfg.play_speed);
    assign phase_sum = SPAN_W'(phase) + speed;
    assign phase_next = (phase_sum >= span) ? PHASE_W'(phase_sum - span)
                                            : phase_sum[PHASE_W-1:0];

    // state update on every tick with a clip loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            global_pos_reg  <= '0;
            segment_pos_reg <= '0;
            trigger_pos_reg <= '0;
            phase_reg       <= '0;
        end
        else if (accept && is_tick && !no_clip)
        begin
            global_pos_reg  <= global_pos_next;
            segment_pos_reg <= segment_pos_next;
            trigger_pos_reg <= trigger_pos_next;
            phase_reg       <= phase_next;
        end
    end

    // item handed to the remainder pipeline
    always_comb
    begin
        entry.tick       = is_tick;
        entry.no_clip    = no_clip;
        entry.load_index = item.load_index[FRAME_AW-1:0];
        entry.frame      = {item.load_left, item.load_right};
        entry.dividend   = LEN_W'(trig) + LEN_W'(phase[PHASE_W-1:FRACTION_BITS]);
        entry.rem        = '0;
    end

endmodule

@@ hdl/rgp_mod_pipe.sv @@
// ----------------------------------------------------------------------------
// rgp_mod_pipe
// Pipelined restoring remainder: read offset modulo clip length, a few bits
// per stage. Load items ride along so store order is kept.
// ----------------------------------------------------------------------------
module rgp_mod_pipe
    import rgp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [LEN_W-1:0] divisor,
    input  logic             in_valid,
    output logic             in_stall,
    input  pipe_item_t       in_entry,
    output logic             out_valid,
    input  logic             out_stall,
    output pipe_item_t       out_entry
);

    localparam int STEPS_PER_STAGE = 3;
    localparam int N_STAGES        = (LEN_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int DEPTH           = N_STAGES + 1;

    logic             valid_reg [DEPTH];
    pipe_item_t       stage_reg [DEPTH];
    logic             valid_in  [DEPTH];
    pipe_item_t       stage_in  [DEPTH];
    logic [DEPTH:0]   ready;

    assign ready[DEPTH] = !out_stall;
    assign valid_in[0]  = in_valid;
    assign stage_in[0]  = in_entry;

    genvar j;
    generate
        for (j = 0; j < DEPTH; j++)
        begin : g_stage
            // a stage loads when empty or when its content moves on
            assign ready[j] = !valid_reg[j] || ready[j+1];

            if (j > 0)
            begin : g_step
                // remainder steps of this stage
                always_comb
                begin
                    logic [LEN_W:0]   r;
                    logic [LEN_W-1:0] d;
                    r = {1'b0, stage_reg[j-1].rem};
                    d = stage_reg[j-1].dividend;
                    for (int k = 0; k < STEPS_PER_STAGE; k++)
                    begin
                        if ((j - 1) * STEPS_PER_STAGE + k < LEN_W)
                        begin
                            r = {r[LEN_W-1:0], d[LEN_W-1]};
                            d = {d[LEN_W-2:0], 1'b0};
                            if (r >= {1'b0, divisor})
                            begin
                                r = r - {1'b0, divisor};
                            end
                        end
                    end
                    stage_in[j]          = stage_reg[j-1];
                    stage_in[j].dividend = d;
                    stage_in[j].rem      = r[LEN_W-1:0];
                end
                assign valid_in[j] = valid_reg[j-1];
            end

            // stage valid
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[j] <= 1'b0;
                end
                else if (ready[j])
                begin
                    valid_reg[j] <= valid_in[j];
                end
            end

            // stage payload
            always_ff @(posedge clk)
            begin
                if (ready[j])
                begin
                    stage_reg[j] <= stage_in[j];
                end
            end
        end
    endgenerate

    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[DEPTH-1];
    assign out_entry = stage_reg[DEPTH-1];

endmodule

@@ hdl/retrigger_glitch_player_core.sv @@
// ----------------------------------------------------------------------------
// retrigger_glitch_player_core
// Stereo clip store played back as a retrigger stutter.
// ----------------------------------------------------------------------------
// Load items write one stereo frame into a 65536 frame store; tick items
// return one frame each, read at the latched trigger point plus the integer
// part of a Q16.8 grain phase, wrapped to the clip length. With no clip
// loaded a tick returns zeros. One item is taken every clock cycle while the
// output does not stall. The accepting edge loads the input register; the
// item then passes six stages of the pipelined remainder that wraps the
// read offset to the clip length (up to three bits per stage), the store
// read register and the output register. Loads pass through the same
// pipeline, so store writes and reads keep item order. The store is not
// cleared; reading a frame that was never loaded gives undefined samples.
module retrigger_glitch_player_core
    import rgp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item
);

    logic [LEN_W-1:0]   clip_length_reg;
    logic [LEN_W-1:0]   grain_length_reg;
    logic [SPEED_W-1:0] play_speed_reg;
    logic [CH_W-1:0]    channel_count_reg;
    cfg_t               cfg;
    logic [LEN_W-1:0]   clip_eff;

    pipe_item_t         entry;
    logic               pipe_out_valid;
    logic               pipe_out_stall;
    pipe_item_t         pipe_out;
    logic               pipe_adv;

    logic               ram_wr_en;
    logic               ram_rd_en;
    logic [FRAME_W-1:0] ram_rd_data;

    logic               rd_valid_reg;
    logic               rd_zero_reg;
    logic               rd_mono_reg;
    logic [15:0]        rd_index_reg;
    logic               rd_ready;

    logic               out_valid_reg;
    out_item_t          out_item_reg;
    out_item_t          out_item_next;
    logic               out_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_length_reg   <= '0;
            grain_length_reg  <= LEN_W'(1);
            play_speed_reg    <= '0;
            channel_count_reg <= CH_W'(2);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CLIP_LENGTH:   clip_length_reg   <= cfg_data;
                CFG_GRAIN_LENGTH:  grain_length_reg  <= cfg_data;
                CFG_PLAY_SPEED:    play_speed_reg    <= cfg_data[SPEED_W-1:0];
                CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CH_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.clip_length   = clip_length_reg;
    assign cfg.grain_length  = grain_length_reg;
    assign cfg.play_speed    = play_speed_reg;
    assign cfg.channel_count = channel_count_reg;
    assign clip_eff          = clip_limit(clip_length_reg);

    // position state and raw read offset
    rgp_phase u_phase (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_valid && !in_stall),
        .item   (in_item),
        .cfg    (cfg),
        .clip   (clip_eff),
        .entry  (entry)
    );

    // read offset modulo clip length
    rgp_mod_pipe u_mod_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .divisor   (clip_eff),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_entry  (entry),
        .out_valid (pipe_out_valid),
        .out_stall (pipe_out_stall),
        .out_entry (pipe_out)
    );

    // handshake between pipeline, read stage and output register
    assign out_ready      = !out_valid_reg || !out_stall;
    assign rd_ready       = !rd_valid_reg || out_ready;
    assign pipe_out_stall = !rd_ready;
    assign pipe_adv       = pipe_out_valid && rd_ready;

    assign ram_wr_en = pipe_adv && !pipe_out.tick;
    assign ram_rd_en = pipe_adv && pipe_out.tick && !pipe_out.no_clip;

    // sample store
    rgp_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (MAX_FRAMES)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (pipe_out.load_index),
        .wr_data (pipe_out.frame),
        .rd_en   (ram_rd_en),
        .rd_addr (pipe_out.rem[FRAME_AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // read stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else if (rd_ready)
        begin
            rd_valid_reg <= pipe_adv && pipe_out.tick;
        end
    end

    // read stage payload
    always_ff @(posedge clk)
    begin
        if (rd_ready)
        begin
            rd_zero_reg  <= pipe_out.no_clip;
            rd_mono_reg  <= (channel_count_reg == CH_MONO);
            rd_index_reg <= pipe_out.no_clip ? 16'd0 : pipe_out.rem[15:0];
        end
    end

    // result item from the store word
    always_comb
    begin
        if (rd_zero_reg)
        begin
            out_item_next = '0;
        end
        else
        begin
            out_item_next.out_left   = ram_rd_data[FRAME_W-1:SAMPLE_BITS];
            out_item_next.out_right  = rd_mono_reg ? ram_rd_data[FRAME_W-1:SAMPLE_BITS]
                                                   : ram_rd_data[SAMPLE_BITS-1:0];
            out_item_next.read_index = rd_index_reg;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= rd_valid_reg;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
